### hw/rtl/wfpc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wfpc_pkg
// Shared types and constants for the 802.11 frame protocol classifier.
// ----------------------------------------------------------------------------
package wfpc_pkg;

    localparam int MAX_FRAME_BYTES = 4095;
    localparam int POS_W           = $clog2(MAX_FRAME_BYTES + 1);
    // compare width: holds the largest header offset (104) without wrapping
    localparam int CMP_W           = (POS_W > 7) ? POS_W + 1 : 8;

    localparam logic [1:0] KIND_MGMT = 2'd0;
    localparam logic [1:0] KIND_CTRL = 2'd1;
    localparam logic [1:0] KIND_DATA = 2'd2;
    localparam logic [1:0] KIND_MISC = 2'd3;

    localparam logic [1:0] FTYPE_MGMT = 2'd0;
    localparam logic [1:0] FTYPE_DATA = 2'd2;

    localparam logic [1:0] FILT_ALL   = 2'd0;
    localparam logic [1:0] FILT_PROTO = 2'd1;
    localparam logic [1:0] FILT_DATA  = 2'd2;
    localparam logic [1:0] FILT_MGMT  = 2'd3;

    localparam logic [15:0] ETH_ARP  = 16'h0806;
    localparam logic [15:0] ETH_IPV6 = 16'h86DD;
    localparam logic [15:0] ETH_IPV4 = 16'h0800;
    localparam logic [23:0] LLC_SNAP = 24'hAAAA03;

    localparam logic [7:0] IPPROTO_ICMP = 8'd1;
    localparam logic [7:0] IPPROTO_TCP  = 8'd6;
    localparam logic [7:0] IPPROTO_UDP  = 8'd17;

    localparam logic [15:0] PORT_DHCP_S = 16'd67;
    localparam logic [15:0] PORT_DHCP_C = 16'd68;
    localparam logic [15:0] PORT_MDNS   = 16'd5353;
    localparam logic [15:0] PORT_DNS    = 16'd53;
    localparam logic [15:0] PORT_HTTP   = 16'd80;
    localparam logic [15:0] PORT_HTTPS  = 16'd443;

    localparam logic [3:0] CLS_UNKNOWN   = 4'd0;
    localparam logic [3:0] CLS_PROTECTED = 4'd1;
    localparam logic [3:0] CLS_ARP       = 4'd2;
    localparam logic [3:0] CLS_IPV6      = 4'd3;
    localparam logic [3:0] CLS_IPV4      = 4'd4;
    localparam logic [3:0] CLS_ICMP      = 4'd5;
    localparam logic [3:0] CLS_UDP       = 4'd6;
    localparam logic [3:0] CLS_DHCP      = 4'd7;
    localparam logic [3:0] CLS_MDNS      = 4'd8;
    localparam logic [3:0] CLS_DNS       = 4'd9;
    localparam logic [3:0] CLS_TCP       = 4'd10;
    localparam logic [3:0] CLS_HTTP      = 4'd11;
    localparam logic [3:0] CLS_HTTPS     = 4'd12;

    // frame state captured byte by byte
    typedef struct packed {
        logic [POS_W-1:0]  len;
        logic [1:0]        kind;
        logic [15:0]       fc;
        logic [2:0][47:0]  addr;
        logic [39:0]       snap;
        logic [3:0]        ihl;
        logic [7:0]        proto;
        logic [1:0][31:0]  ip;
        logic [1:0][15:0]  port;
    } frame_rec_t;

    typedef struct packed {
        logic [31:0] seq_id;
        logic [1:0]  frame_type;
        logic [3:0]  frame_subtype;
        logic        protected_flag;
        logic [3:0]  protocol_class;
        logic [47:0] receiver_addr;
        logic [47:0] transmitter_addr;
        logic [47:0] third_addr;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [15:0] src_port;
        logic [15:0] dst_port;
    } result_t;

    // 802.11 payload offset from DS bits and QoS subtype bit
    function automatic logic [CMP_W-1:0] payload_offset(input logic [15:0] fc);
        logic [CMP_W-1:0] po;
        po = CMP_W'(24);
        if (fc[9:8] == 2'b11) po = po + CMP_W'(6);
        if (fc[7]) po = po + CMP_W'(2);
        return po;
    endfunction

endpackage
`default_nettype wire

### hw/rtl/wfpc_capture.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wfpc_capture
// Byte-wise header capture; hands a frame record over on the last byte.
// ----------------------------------------------------------------------------
module wfpc_capture import wfpc_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  frame_byte,
    input  wire logic        last_byte,
    input  wire logic [1:0]  rx_kind,
    output logic             rec_valid,
    output frame_rec_t       rec,
    input  wire logic        rec_ready
);

    frame_rec_t st_reg, st_next;
    frame_rec_t rec_reg;
    logic       rec_valid_reg;
    logic       accept;

    logic [CMP_W-1:0] p, po, no, to;
    logic [15:0]      ether;

    assign in_ready  = !rec_valid_reg || rec_ready;
    assign accept    = in_valid && in_ready;
    assign rec_valid = rec_valid_reg;
    assign rec       = rec_reg;

    always_comb begin
        st_next = st_reg;
        p       = CMP_W'(st_reg.len);
        po      = payload_offset(st_reg.fc);
        no      = po + CMP_W'(8);
        to      = no + CMP_W'({st_reg.ihl, 2'b00});
        ether   = st_reg.snap[15:0];
        if (st_reg.len < POS_W'(MAX_FRAME_BYTES)) begin
            st_next.len = st_reg.len + POS_W'(1);
            if (p == CMP_W'(0)) begin
                st_next.fc[7:0] = frame_byte;
            end else if (p == CMP_W'(1)) begin
                st_next.fc[15:8] = frame_byte;
            end else if (p >= CMP_W'(4) && p < CMP_W'(10)) begin
                st_next.addr[0] = {st_reg.addr[0][39:0], frame_byte};
            end else if (p >= CMP_W'(10) && p < CMP_W'(16)) begin
                st_next.addr[1] = {st_reg.addr[1][39:0], frame_byte};
            end else if (p >= CMP_W'(16) && p < CMP_W'(22)) begin
                st_next.addr[2] = {st_reg.addr[2][39:0], frame_byte};
            end else if ((p >= po && p < po + CMP_W'(3)) || p == po + CMP_W'(6)
                         || p == po + CMP_W'(7)) begin
                st_next.snap = {st_reg.snap[31:0], frame_byte};
            end else if (ether == ETH_ARP) begin
                if (p >= no + CMP_W'(14) && p < no + CMP_W'(18)) begin
                    st_next.ip[0] = {st_reg.ip[0][23:0], frame_byte};
                end else if (p >= no + CMP_W'(24) && p < no + CMP_W'(28)) begin
                    st_next.ip[1] = {st_reg.ip[1][23:0], frame_byte};
                end
            end else if (p == no) begin
                st_next.ihl = frame_byte[3:0];
            end else if (p == no + CMP_W'(9)) begin
                st_next.proto = frame_byte;
            end else if (p >= no + CMP_W'(12) && p < no + CMP_W'(16)) begin
                st_next.ip[0] = {st_reg.ip[0][23:0], frame_byte};
            end else if (p >= no + CMP_W'(16) && p < no + CMP_W'(20)) begin
                st_next.ip[1] = {st_reg.ip[1][23:0], frame_byte};
            end else if (st_reg.ihl >= 4'd5) begin
                if (p >= to && p < to + CMP_W'(2)) begin
                    st_next.port[0] = {st_reg.port[0][7:0], frame_byte};
                end else if (p >= to + CMP_W'(2) && p < to + CMP_W'(4)) begin
                    st_next.port[1] = {st_reg.port[1][7:0], frame_byte};
                end
            end
        end
        st_next.kind = rx_kind;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg        <= '0;
            rec_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                st_reg <= last_byte ? '0 : st_next;
            end
            if (accept && last_byte) begin
                rec_valid_reg <= 1'b1;
            end else if (rec_ready) begin
                rec_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && last_byte) begin
            rec_reg <= st_next;
        end
    end

    a_pos_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg.len <= POS_W'(MAX_FRAME_BYTES))
        else $error("byte position past frame bound");

    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && last_byte) |=> (st_reg.len == '0 && rec_valid_reg))
        else $error("frame state not cleared or record not posted after last byte");

    a_rec_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (rec_valid_reg && !rec_ready) |=> (rec_valid_reg && $stable(rec_reg)))
        else $error("frame record changed while waiting");

endmodule
`default_nettype wire

### hw/rtl/wfpc_classify.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wfpc_classify
// Classifies a captured frame, counts it, filters it and holds the result.
// ----------------------------------------------------------------------------
module wfpc_classify import wfpc_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_wdata,
    input  wire logic        rec_valid,
    input  wire frame_rec_t  rec,
    output logic             rec_ready,
    output logic             res_valid,
    output result_t          res,
    input  wire logic        res_ready
);

    logic [1:0]  filter_mode_reg;
    logic [31:0] seq_reg;
    logic        res_valid_reg;
    result_t     res_reg, res_next;

    logic [CMP_W-1:0] len, po, no, hl, to;
    logic [15:0]      ether, sp, dp;
    logic [1:0]       ftype;
    logic [3:0]       cls;
    logic [31:0]      sip, dip;
    logic             counted, keep, take;

    assign rec_ready = !res_valid_reg || res_ready;
    assign take      = rec_valid && rec_ready;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_comb begin
        len   = CMP_W'(rec.len);
        po    = payload_offset(rec.fc);
        no    = po + CMP_W'(8);
        hl    = CMP_W'({rec.ihl, 2'b00});
        to    = no + hl;
        ether = rec.snap[15:0];
        ftype = rec.fc[3:2];
        cls   = CLS_UNKNOWN;
        sip   = '0;
        dip   = '0;
        sp    = '0;
        dp    = '0;
        counted = (rec.kind != KIND_MISC) && (len >= CMP_W'(2));
        if (rec.fc[14]) begin
            cls = CLS_PROTECTED;
        end else if (rec.kind == KIND_DATA && len >= CMP_W'(32) && len >= no
                     && rec.snap[39:16] == LLC_SNAP) begin
            if (ether == ETH_ARP) begin
                cls = CLS_ARP;
                if (len >= no + CMP_W'(28)) begin
                    sip = rec.ip[0];
                    dip = rec.ip[1];
                end
            end else if (ether == ETH_IPV6) begin
                cls = CLS_IPV6;
            end else if (ether == ETH_IPV4 && len >= no + CMP_W'(20)) begin
                cls = CLS_IPV4;
                if (rec.ihl >= 4'd5 && len >= to) begin
                    sip = rec.ip[0];
                    dip = rec.ip[1];
                    if (rec.proto == IPPROTO_ICMP) begin
                        cls = CLS_ICMP;
                    end else if ((rec.proto == IPPROTO_TCP || rec.proto == IPPROTO_UDP)
                                 && len >= to + CMP_W'(4)) begin
                        sp = rec.port[0];
                        dp = rec.port[1];
                        if (rec.proto == IPPROTO_UDP) begin
                            cls = CLS_UDP;
                            if (sp == PORT_DHCP_S || sp == PORT_DHCP_C ||
                                dp == PORT_DHCP_S || dp == PORT_DHCP_C) begin
                                cls = CLS_DHCP;
                            end else if (sp == PORT_MDNS || dp == PORT_MDNS) begin
                                cls = CLS_MDNS;
                            end else if (sp == PORT_DNS || dp == PORT_DNS) begin
                                cls = CLS_DNS;
                            end
                        end else begin
                            cls = CLS_TCP;
                            if (sp == PORT_HTTP || dp == PORT_HTTP) begin
                                cls = CLS_HTTP;
                            end else if (sp == PORT_HTTPS || dp == PORT_HTTPS) begin
                                cls = CLS_HTTPS;
                            end
                        end
                    end
                end
            end
        end

        unique case (filter_mode_reg)
            FILT_ALL:   keep = 1'b1;
            FILT_PROTO: keep = (ftype == FTYPE_DATA) || (cls != CLS_UNKNOWN);
            FILT_DATA:  keep = (ftype == FTYPE_DATA);
            FILT_MGMT:  keep = (ftype == FTYPE_MGMT);
            default:    keep = 1'b1;
        endcase

        res_next.seq_id           = seq_reg + 32'd1;
        res_next.frame_type       = ftype;
        res_next.frame_subtype    = rec.fc[7:4];
        res_next.protected_flag   = rec.fc[14];
        res_next.protocol_class   = cls;
        res_next.receiver_addr    = (len >= CMP_W'(10)) ? rec.addr[0] : '0;
        res_next.transmitter_addr = (len >= CMP_W'(16)) ? rec.addr[1] : '0;
        res_next.third_addr       = (len >= CMP_W'(22)) ? rec.addr[2] : '0;
        res_next.src_ip           = sip;
        res_next.dst_ip           = dip;
        res_next.src_port         = sp;
        res_next.dst_port         = dp;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filter_mode_reg <= FILT_ALL;
            seq_reg         <= '0;
            res_valid_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                filter_mode_reg <= cfg_wdata;
            end
            if (take && counted) begin
                seq_reg <= seq_reg + 32'd1;
            end
            if (take) begin
                res_valid_reg <= counted && keep;
            end else if (res_ready) begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take && counted && keep) begin
            res_reg <= res_next;
        end
    end

    a_seq_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && counted) |=> seq_reg == $past(seq_reg) + 32'd1)
        else $error("sequence counter did not step by one");

    a_res_from_rec: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(res_valid_reg) |-> $past(take && counted && keep))
        else $error("result appeared without a counted record");

    a_prot_class: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid_reg && res_reg.protected_flag) |-> res_reg.protocol_class == CLS_PROTECTED)
        else $error("protected frame with non-protected class");

endmodule
`default_nettype wire

### hw/rtl/wifi_frame_protocol_classifier.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wifi_frame_protocol_classifier
// 802.11 frame parser: header fields, LLC/SNAP, ARP/IPv4/IPv6 and port class.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake          Payload
// s_       in   s_valid/s_ready    s_frame_byte, s_last_byte, s_rx_kind
// m_       out  m_valid/m_ready    m_seq_id .. m_dst_port (at most one record per frame)
// cfg_     in   cfg_we             cfg_wdata (filter mode)
//
// One frame byte per cycle while s_ready is high. After the last byte a record
// passes the capture register, then the classify/result register.
// Reset clears frame state, sequence counter and filter mode.
// s_ready drops only while a finished frame record waits behind a stalled m_.
// ----------------------------------------------------------------------------
module wifi_frame_protocol_classifier import wfpc_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_wdata,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_frame_byte,
    input  wire logic        s_last_byte,
    input  wire logic [1:0]  s_rx_kind,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_seq_id,
    output logic [1:0]       m_frame_type,
    output logic [3:0]       m_frame_subtype,
    output logic             m_protected_flag,
    output logic [3:0]       m_protocol_class,
    output logic [47:0]      m_receiver_addr,
    output logic [47:0]      m_transmitter_addr,
    output logic [47:0]      m_third_addr,
    output logic [31:0]      m_src_ip,
    output logic [31:0]      m_dst_ip,
    output logic [15:0]      m_src_port,
    output logic [15:0]      m_dst_port
);

    frame_rec_t rec;
    logic       rec_valid, rec_ready;
    result_t    res;

    wfpc_capture u_capture (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .frame_byte (s_frame_byte),
        .last_byte  (s_last_byte),
        .rx_kind    (s_rx_kind),
        .rec_valid  (rec_valid),
        .rec        (rec),
        .rec_ready  (rec_ready)
    );

    wfpc_classify u_classify (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .rec_valid (rec_valid),
        .rec       (rec),
        .rec_ready (rec_ready),
        .res_valid (m_valid),
        .res       (res),
        .res_ready (m_ready)
    );

    assign m_seq_id           = res.seq_id;
    assign m_frame_type       = res.frame_type;
    assign m_frame_subtype    = res.frame_subtype;
    assign m_protected_flag   = res.protected_flag;
    assign m_protocol_class   = res.protocol_class;
    assign m_receiver_addr    = res.receiver_addr;
    assign m_transmitter_addr = res.transmitter_addr;
    assign m_third_addr       = res.third_addr;
    assign m_src_ip           = res.src_ip;
    assign m_dst_ip           = res.dst_ip;
    assign m_src_port         = res.src_port;
    assign m_dst_port         = res.dst_port;

endmodule
`default_nettype wire

### sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the 802.11 frame protocol classifier. Frames are
// streamed byte by byte with random gaps and output stalls; a byte-level
// frame model predicts each record, and every output transfer is checked
// against the oldest prediction. The run walks through all filter modes.
// ----------------------------------------------------------------------------
module testbench;
    import wfpc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES = 400000;
    localparam int SETTLE       = 8;
    localparam int PHASE_ITEMS  = 60;
    localparam int CUT_NATURAL  = 0;
    localparam int CUT_RANDOM   = -1;

    typedef enum int { L3_RAW, L3_ARP, L3_IPV4, L3_IPV6 } l3_e;

    typedef struct {
        logic [7:0] data;
        logic       last;
        logic [1:0] kind;
    } byte_item_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_wdata = 2'd0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    logic [7:0]  s_frame_byte = 8'd0;
    logic        s_last_byte  = 1'b0;
    logic [1:0]  s_rx_kind    = 2'd0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_seq_id;
    logic [1:0]  m_frame_type;
    logic [3:0]  m_frame_subtype;
    logic        m_protected_flag;
    logic [3:0]  m_protocol_class;
    logic [47:0] m_receiver_addr;
    logic [47:0] m_transmitter_addr;
    logic [47:0] m_third_addr;
    logic [31:0] m_src_ip;
    logic [31:0] m_dst_ip;
    logic [15:0] m_src_port;
    logic [15:0] m_dst_port;

    wifi_frame_protocol_classifier dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_we             (cfg_we),
        .cfg_wdata          (cfg_wdata),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_frame_byte       (s_frame_byte),
        .s_last_byte        (s_last_byte),
        .s_rx_kind          (s_rx_kind),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_seq_id           (m_seq_id),
        .m_frame_type       (m_frame_type),
        .m_frame_subtype    (m_frame_subtype),
        .m_protected_flag   (m_protected_flag),
        .m_protocol_class   (m_protocol_class),
        .m_receiver_addr    (m_receiver_addr),
        .m_transmitter_addr (m_transmitter_addr),
        .m_third_addr       (m_third_addr),
        .m_src_ip           (m_src_ip),
        .m_dst_ip           (m_dst_ip),
        .m_src_port         (m_src_port),
        .m_dst_port         (m_dst_port)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // stimulus and expectation stores
    byte_item_t byte_q[$];
    result_t    record_q[$];
    logic [7:0] frm[$];
    byte_item_t drv_item;

    int  queued   = 0;
    int  accepted = 0;
    int  checked  = 0;
    int  errors   = 0;
    int  cycles   = 0;
    bit  in_taken = 1'b0;
    bit  no_idle  = 1'b0;

    // frame model state
    logic [1:0]        mode_r;
    logic [POS_W-1:0]  pos_r;
    logic [15:0]       fc_r;
    logic [47:0]       addr_r[3];
    logic [39:0]       snap_r;
    logic [3:0]        ihl_r;
    logic [7:0]        proto_r;
    logic [31:0]       ip_r[2];
    logic [15:0]       port_r[2];
    logic [31:0]       seq_r;

    function automatic int hdr_len(logic [15:0] f);
        int o = 24;
        if (f[9:8] == 2'b11) o += 6;
        if (f[7]) o += 2;
        return o;
    endfunction

    task automatic clear_frame();
        pos_r     = '0;
        fc_r      = '0;
        addr_r[0] = '0;
        addr_r[1] = '0;
        addr_r[2] = '0;
        snap_r    = '0;
        ihl_r     = '0;
        proto_r   = '0;
        ip_r[0]   = '0;
        ip_r[1]   = '0;
        port_r[0] = '0;
        port_r[1] = '0;
    endtask

    task automatic capture_byte(int p, logic [7:0] b);
        int po, no, k, to;
        po = hdr_len(fc_r);
        no = po + 8;
        if (p == 0) begin
            fc_r[7:0] = b;
        end else if (p == 1) begin
            fc_r[15:8] = b;
        end else if (p >= 4 && p < 22) begin
            k = (p - 4) / 6;
            addr_r[k] = {addr_r[k][39:0], b};
        end else if ((p >= po && p < po + 3) || p == po + 6 || p == po + 7) begin
            snap_r = {snap_r[31:0], b};
        end else if (snap_r[15:0] == ETH_ARP) begin
            if (p >= no + 14 && p < no + 18) begin
                ip_r[0] = {ip_r[0][23:0], b};
            end else if (p >= no + 24 && p < no + 28) begin
                ip_r[1] = {ip_r[1][23:0], b};
            end
        end else if (p == no) begin
            ihl_r = b[3:0];
        end else if (p == no + 9) begin
            proto_r = b;
        end else if (p >= no + 12 && p < no + 16) begin
            ip_r[0] = {ip_r[0][23:0], b};
        end else if (p >= no + 16 && p < no + 20) begin
            ip_r[1] = {ip_r[1][23:0], b};
        end else if (ihl_r >= 4'd5) begin
            to = no + int'(ihl_r) * 4;
            if (p >= to && p < to + 2) begin
                port_r[0] = {port_r[0][7:0], b};
            end else if (p >= to + 2 && p < to + 4) begin
                port_r[1] = {port_r[1][7:0], b};
            end
        end
    endtask

    // advance the frame model by one byte; a finished frame may yield a record
    task automatic classify_byte(logic [7:0] b, logic last, logic [1:0] kind);
        int          len, po, no, hl, to;
        logic [3:0]  cls;
        logic [31:0] sip, dip;
        logic [15:0] sp, dp;
        logic [1:0]  ft;
        logic        keep;
        result_t     r;
        if (pos_r < POS_W'(MAX_FRAME_BYTES)) begin
            capture_byte(int'(pos_r), b);
            pos_r++;
        end
        if (last) begin
            len = int'(pos_r);
            if (kind == KIND_MISC || len < 2) begin
                clear_frame();
            end else begin
                seq_r++;
                cls = CLS_UNKNOWN;
                sip = '0;
                dip = '0;
                sp  = '0;
                dp  = '0;
                ft  = fc_r[3:2];
                po  = hdr_len(fc_r);
                no  = po + 8;
                if (fc_r[14]) begin
                    cls = CLS_PROTECTED;
                end else if (kind == KIND_DATA && len >= 32 && len >= po + 8 &&
                             snap_r[39:16] == LLC_SNAP) begin
                    if (snap_r[15:0] == ETH_ARP) begin
                        cls = CLS_ARP;
                        if (len >= no + 28) begin
                            sip = ip_r[0];
                            dip = ip_r[1];
                        end
                    end else if (snap_r[15:0] == ETH_IPV6) begin
                        cls = CLS_IPV6;
                    end else if (snap_r[15:0] == ETH_IPV4 && len >= no + 20) begin
                        cls = CLS_IPV4;
                        hl = int'(ihl_r) * 4;
                        if (hl >= 20 && len >= no + hl) begin
                            sip = ip_r[0];
                            dip = ip_r[1];
                            to  = no + hl;
                            if (proto_r == IPPROTO_ICMP) begin
                                cls = CLS_ICMP;
                            end else if ((proto_r == IPPROTO_TCP || proto_r == IPPROTO_UDP)
                                         && len >= to + 4) begin
                                sp = port_r[0];
                                dp = port_r[1];
                                if (proto_r == IPPROTO_UDP) begin
                                    if (sp == PORT_DHCP_S || sp == PORT_DHCP_C ||
                                        dp == PORT_DHCP_S || dp == PORT_DHCP_C) begin
                                        cls = CLS_DHCP;
                                    end else if (sp == PORT_MDNS || dp == PORT_MDNS) begin
                                        cls = CLS_MDNS;
                                    end else if (sp == PORT_DNS || dp == PORT_DNS) begin
                                        cls = CLS_DNS;
                                    end else begin
                                        cls = CLS_UDP;
                                    end
                                end else if (sp == PORT_HTTP || dp == PORT_HTTP) begin
                                    cls = CLS_HTTP;
                                end else if (sp == PORT_HTTPS || dp == PORT_HTTPS) begin
                                    cls = CLS_HTTPS;
                                end else begin
                                    cls = CLS_TCP;
                                end
                            end
                        end
                    end
                end
                case (mode_r)
                    FILT_PROTO: keep = (ft == FTYPE_DATA) || (cls != CLS_UNKNOWN);
                    FILT_DATA:  keep = (ft == FTYPE_DATA);
                    FILT_MGMT:  keep = (ft == FTYPE_MGMT);
                    default:    keep = 1'b1;
                endcase
                r.seq_id           = seq_r;
                r.frame_type       = ft;
                r.frame_subtype    = fc_r[7:4];
                r.protected_flag   = fc_r[14];
                r.protocol_class   = cls;
                r.receiver_addr    = (len >= 10) ? addr_r[0] : '0;
                r.transmitter_addr = (len >= 16) ? addr_r[1] : '0;
                r.third_addr       = (len >= 22) ? addr_r[2] : '0;
                r.src_ip           = sip;
                r.dst_ip           = dip;
                r.src_port         = sp;
                r.dst_port         = dp;
                if (keep) record_q.push_back(r);
                clear_frame();
            end
        end
    endtask

    task automatic check_field(string name, logic [47:0] want, logic [47:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            errors++;
        end
    endtask

    task automatic check_record();
        result_t w;
        if (record_q.size() == 0) begin
            $error("record seq_id 0x%0h with nothing expected", m_seq_id);
            errors++;
        end else begin
            w = record_q.pop_front();
            checked++;
            check_field("seq_id", 48'(w.seq_id), 48'(m_seq_id));
            check_field("frame_type", 48'(w.frame_type), 48'(m_frame_type));
            check_field("frame_subtype", 48'(w.frame_subtype), 48'(m_frame_subtype));
            check_field("protected_flag", 48'(w.protected_flag), 48'(m_protected_flag));
            check_field("protocol_class", 48'(w.protocol_class), 48'(m_protocol_class));
            check_field("receiver_addr", w.receiver_addr, m_receiver_addr);
            check_field("transmitter_addr", w.transmitter_addr, m_transmitter_addr);
            check_field("third_addr", w.third_addr, m_third_addr);
            check_field("src_ip", 48'(w.src_ip), 48'(m_src_ip));
            check_field("dst_ip", 48'(w.dst_ip), 48'(m_dst_ip));
            check_field("src_port", 48'(w.src_port), 48'(m_src_port));
            check_field("dst_port", 48'(w.dst_port), 48'(m_dst_port));
        end
    endtask

    // sample transfers on both channels
    always @(posedge aclk) begin
        cycles++;
        if (aresetn) begin
            if (m_valid && m_ready) check_record();
            in_taken = s_valid && s_ready;
            if (in_taken) begin
                accepted++;
                classify_byte(s_frame_byte, s_last_byte, s_rx_kind);
            end
        end else begin
            in_taken = 1'b0;
        end
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d records outstanding",
                     cycles, record_q.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // byte driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_taken) begin
            if (byte_q.size() != 0 && (no_idle || $urandom_range(0, 99) >= 31)) begin
                drv_item = byte_q.pop_front();
                s_valid      <= 1'b1;
                s_frame_byte <= drv_item.data;
                s_last_byte  <= drv_item.last;
                s_rx_kind    <= drv_item.kind;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // record sink backpressure
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= no_idle || ($urandom_range(0, 99) >= 31);
        end
    end

    function automatic logic [7:0] rnd8();
        return 8'($urandom);
    endfunction

    function automatic logic [15:0] pick_port();
        case ($urandom_range(0, 11))
            0:       return PORT_DHCP_S;
            1:       return PORT_DHCP_C;
            2:       return PORT_MDNS;
            3:       return PORT_DNS;
            4:       return PORT_HTTP;
            5:       return PORT_HTTPS;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_frame(logic [1:0] last_kind);
        byte_item_t it;
        foreach (frm[i]) begin
            it.data = frm[i];
            it.last = (i == frm.size() - 1);
            it.kind = it.last ? last_kind : 2'($urandom);
            byte_q.push_back(it);
            queued++;
        end
        frm.delete();
    endtask

    task automatic add_frame(input logic [1:0] ftype, input logic [3:0] sub, input bit prot,
                             input logic [1:0] ds, input l3_e l3, input logic [7:0] proto,
                             input logic [3:0] ihl, input logic [15:0] sport,
                             input logic [15:0] dport, input bit bad_snap, input int cut,
                             input logic [1:0] last_kind);
        int         n;
        logic [7:0] r;
        r = rnd8();
        frm.push_back({sub, ftype, r[1:0]});
        r = rnd8();
        frm.push_back({r[7], prot, r[5:2], ds});
        repeat (22) frm.push_back(rnd8());
        if (ds == 2'b11) repeat (6) frm.push_back(rnd8());
        if (sub[3]) repeat (2) frm.push_back(rnd8());
        if (bad_snap) begin
            repeat (3) frm.push_back(rnd8());
        end else begin
            frm.push_back(LLC_SNAP[23:16]);
            frm.push_back(LLC_SNAP[15:8]);
            frm.push_back(LLC_SNAP[7:0]);
        end
        repeat (3) frm.push_back(rnd8());
        case (l3)
            L3_ARP: begin
                frm.push_back(ETH_ARP[15:8]);
                frm.push_back(ETH_ARP[7:0]);
                repeat (28) frm.push_back(rnd8());
            end
            L3_IPV6: begin
                frm.push_back(ETH_IPV6[15:8]);
                frm.push_back(ETH_IPV6[7:0]);
                repeat (40) frm.push_back(rnd8());
            end
            L3_IPV4: begin
                frm.push_back(ETH_IPV4[15:8]);
                frm.push_back(ETH_IPV4[7:0]);
                frm.push_back({4'h4, ihl});
                repeat (8) frm.push_back(rnd8());
                frm.push_back(proto);
                repeat (10) frm.push_back(rnd8());
                if (ihl > 4'd5) repeat ((int'(ihl) - 5) * 4) frm.push_back(rnd8());
                frm.push_back(sport[15:8]);
                frm.push_back(sport[7:0]);
                frm.push_back(dport[15:8]);
                frm.push_back(dport[7:0]);
                repeat ($urandom_range(0, 12)) frm.push_back(rnd8());
            end
            default: begin
                repeat (2) frm.push_back(rnd8());
                repeat ($urandom_range(0, 20)) frm.push_back(rnd8());
            end
        endcase
        if (cut == CUT_RANDOM) begin
            n = $urandom_range(2, frm.size());
        end else if (cut > 0) begin
            n = cut;
        end else begin
            n = frm.size();
        end
        while (frm.size() > n) void'(frm.pop_back());
        while (frm.size() < n) frm.push_back(rnd8());
        send_frame(last_kind);
    endtask

    task automatic add_random_frame();
        int         r;
        l3_e        l3;
        logic [7:0] proto;
        logic [3:0] ihl;
        r = $urandom_range(0, 99);
        if (r < 12) begin
            repeat ($urandom_range(1, 40)) frm.push_back(rnd8());
            send_frame(2'($urandom));
        end else if (r < 30) begin
            add_frame(2'($urandom), 4'($urandom), $urandom_range(0, 9) == 0, 2'($urandom),
                      L3_RAW, 8'd0, 4'd0, 16'd0, 16'd0, $urandom_range(0, 1) == 1,
                      ($urandom_range(0, 3) == 0) ? CUT_NATURAL : int'($urandom_range(1, 36)),
                      2'($urandom));
        end else begin
            r = $urandom_range(0, 99);
            if (r < 55) l3 = L3_IPV4;
            else if (r < 70) l3 = L3_ARP;
            else if (r < 80) l3 = L3_IPV6;
            else l3 = L3_RAW;
            r = $urandom_range(0, 99);
            if (r < 20) proto = IPPROTO_ICMP;
            else if (r < 55) proto = IPPROTO_TCP;
            else if (r < 90) proto = IPPROTO_UDP;
            else proto = rnd8();
            r = $urandom_range(0, 9);
            if (r == 0) ihl = 4'($urandom);
            else if (r == 1) ihl = 4'($urandom_range(6, 8));
            else ihl = 4'd5;
            add_frame(FTYPE_DATA, 4'($urandom), $urandom_range(0, 14) == 0, 2'($urandom),
                      l3, proto, ihl, pick_port(), pick_port(), $urandom_range(0, 19) == 0,
                      ($urandom_range(0, 4) == 0) ? CUT_RANDOM : CUT_NATURAL,
                      ($urandom_range(0, 9) == 0) ? 2'($urandom) : KIND_DATA);
        end
    endtask

    task automatic wait_drained();
        while (accepted != queued || record_q.size() != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic write_filter(logic [1:0] m);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        mode_r = m;
    endtask

    initial begin
        logic [1:0] modes[6];
        int         start;
        mode_r = FILT_ALL;
        seq_r  = '0;
        clear_frame();
        modes = '{FILT_PROTO, FILT_DATA, FILT_MGMT, FILT_ALL, 2'd0, 2'd0};
        modes[4] = 2'($urandom);
        modes[5] = 2'($urandom);
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed frames under the reset filter mode
        frm.push_back(8'hFF);
        send_frame(KIND_MGMT);
        add_frame(FTYPE_MGMT, 4'h8, 0, 2'b00, L3_RAW, 8'd0, 4'd0, 16'd0, 16'd0, 0, 2,
                  KIND_MGMT);
        add_frame(FTYPE_MGMT, 4'h8, 0, 2'b00, L3_RAW, 8'd0, 4'd0, 16'd0, 16'd0, 0, 40,
                  KIND_MGMT);
        add_frame(2'd1, 4'hB, 0, 2'b00, L3_RAW, 8'd0, 4'd0, 16'd0, 16'd0, 0, 16, KIND_CTRL);
        add_frame(FTYPE_DATA, 4'h0, 0, 2'b00, L3_IPV4, IPPROTO_UDP, 4'd5, 16'd1234,
                  PORT_DNS, 0, CUT_NATURAL, KIND_MISC);
        add_frame(FTYPE_DATA, 4'h0, 1, 2'b01, L3_IPV4, IPPROTO_TCP, 4'd5, 16'd1000,
                  PORT_HTTP, 0, CUT_NATURAL, KIND_DATA);
        add_frame(FTYPE_DATA, 4'h0, 0, 2'b10, L3_ARP, 8'd0, 4'd0, 16'd0, 16'd0, 0,
                  CUT_NATURAL, KIND_DATA);
        add_frame(FTYPE_DATA, 4'h8, 0, 2'b11, L3_IPV6, 8'd0, 4'd0, 16'd0, 16'd0, 0,
                  CUT_NATURAL, KIND_DATA);
        add_frame(FTYPE_DATA, 4'h0, 0, 2'b00, L3_IPV4, IPPROTO_ICMP, 4'd5, 16'd0, 16'd0, 0,
                  CUT_NATURAL, KIND_DATA);
        add_frame(FTYPE_DATA, 4'h0, 0, 2'b00, L3_IPV4, IPPROTO_UDP, 4'd5, PORT_DHCP_C,
                  PORT_DHCP_S, 0, CUT_NATURAL, KIND_DATA);
        add_frame(FTYPE_DATA, 4'h8, 0, 2'b01, L3_IPV4, IPPROTO_UDP, 4'd5, PORT_MDNS,
                  PORT_MDNS, 0, CUT_NATURAL, KIND_DATA);
        add_frame(FTYPE_DATA, 4'h0, 0, 2'b10, L3_IPV4, IPPROTO_UDP, 4'd5, 16'd40000,
                  PORT_DNS, 0, CUT_NATURAL, KIND_DATA);
        add_frame(FTYPE_DATA, 4'h0, 0, 2'b00, L3_IPV4, IPPROTO_UDP, 4'd5, 16'd4000,
                  16'd5000, 0, CUT_NATURAL, KIND_DATA);
        add_frame(FTYPE_DATA, 4'h0, 0, 2'b00, L3_IPV4, IPPROTO_TCP, 4'd5, 16'd51000,
                  PORT_HTTP, 0, CUT_NATURAL, KIND_DATA);
        add_frame(FTYPE_DATA, 4'h8, 0, 2'b11, L3_IPV4, IPPROTO_TCP, 4'd5, PORT_HTTPS,
                  16'd51001, 0, CUT_NATURAL, KIND_DATA);
        add_frame(FTYPE_DATA, 4'h0, 0, 2'b00, L3_IPV4, IPPROTO_TCP, 4'd5, 16'hFFFF,
                  16'h0000, 0, CUT_NATURAL, KIND_DATA);
        add_frame(FTYPE_DATA, 4'h0, 0, 2'b00, L3_IPV4, IPPROTO_TCP, 4'd3, PORT_HTTP,
                  PORT_HTTP, 0, CUT_NATURAL, KIND_DATA);
        add_frame(FTYPE_DATA, 4'h8, 0, 2'b11, L3_IPV4, IPPROTO_UDP, 4'd15, PORT_DNS,
                  16'd999, 0, CUT_NATURAL, KIND_DATA);
        add_frame(FTYPE_DATA, 4'h0, 0, 2'b00, L3_IPV4, IPPROTO_UDP, 4'd5, PORT_DNS,
                  PORT_DNS, 1, CUT_NATURAL, KIND_DATA);
        add_frame(FTYPE_DATA, 4'h0, 0, 2'b00, L3_IPV4, IPPROTO_TCP, 4'd5, PORT_HTTP,
                  PORT_HTTP, 0, CUT_NATURAL, KIND_MGMT);
        add_frame(FTYPE_DATA, 4'h0, 0, 2'b00, L3_IPV4, IPPROTO_UDP, 4'd5, PORT_DNS,
                  PORT_DNS, 0, 50, KIND_DATA);
        add_frame(FTYPE_DATA, 4'h0, 0, 2'b00, L3_IPV4, IPPROTO_UDP, 4'd5, PORT_DNS,
                  PORT_DNS, 0, 54, KIND_DATA);
        repeat (30) frm.push_back(8'h00);
        send_frame(KIND_DATA);
        repeat (30) frm.push_back(8'hFF);
        send_frame(KIND_DATA);
        wait_drained();

        // random traffic, one phase per filter setting
        for (int ph = 0; ph < 6; ph++) begin
            write_filter(modes[ph]);
            no_idle = (ph == 3);
            start = queued;
            while (queued - start < PHASE_ITEMS) add_random_frame();
            wait_drained();
        end
        no_idle = 1'b0;

        $display("Ran %0d bytes in %0d counted frames; %0d records checked across filter modes",
                 accepted, seq_r, checked);
        $display("including tiny, misc, protected and truncated frames");
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
